// ===== sv/sha1_pkg.sv =====
`default_nettype none
package sha1_pkg;

  localparam int unsigned LengthBitsDefault = 64;
  localparam int unsigned CountBits = 61;
  localparam int unsigned NumRounds = 80;

  localparam logic [31:0] H0Init = 32'h67452301;
  localparam logic [31:0] H1Init = 32'hEFCDAB89;
  localparam logic [31:0] H2Init = 32'h98BADCFE;
  localparam logic [31:0] H3Init = 32'h10325476;
  localparam logic [31:0] H4Init = 32'hC3D2E1F0;

  localparam logic [31:0] K0 = 32'h5A827999;
  localparam logic [31:0] K1 = 32'h6ED9EBA1;
  localparam logic [31:0] K2 = 32'h8F1BBCDC;
  localparam logic [31:0] K3 = 32'hCA62C1D6;

  localparam logic [7:0] PadByte = 8'h80;
  localparam logic [5:0] LenPos = 6'd56;

  typedef enum logic [2:0] {
    StIdle,
    StPadFirst,
    StPadFill,
    StRound,
    StAfter,
    StLen,
    StOut
  } state_e;

  // controller to datapath
  typedef struct packed {
    logic load_byte;
    logic pad_byte;
    logic zero_byte;
    logic load_len;
    logic start_comp;
    logic round;
    logic finish_comp;
    logic clear_msg;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic [5:0] pos;
    logic       last_round;
  } status_t;

endpackage
`default_nettype wire

// ===== sv/sha1_if.sv =====
`default_nettype none
interface sha1_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       byte_present;
  logic       end_of_message;
  modport source (output valid, data_byte, byte_present, end_of_message, input ready);
  modport sink (input valid, data_byte, byte_present, end_of_message, output ready);
endinterface

interface sha1_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] digest_word;
  logic [2:0]  word_index;
  logic        last_word;
  modport source (output valid, digest_word, word_index, last_word, input ready);
  modport sink (input valid, digest_word, word_index, last_word, output ready);
endinterface
`default_nettype wire

// ===== sv/sha1_dp.sv =====
`default_nettype none
module sha1_dp #(
  parameter int unsigned LengthBits = sha1_pkg::LengthBitsDefault
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic [7:0]       data_byte_i,
  input  wire sha1_pkg::cmd_t   cmd_i,
  input  wire logic [2:0]       out_sel_i,
  output sha1_pkg::status_t     status_o,
  output logic [31:0]           digest_o
);

  localparam int unsigned CB = sha1_pkg::CountBits;

  logic [31:0] w_q [16];
  logic [31:0] h_q [5];
  logic [31:0] v_q [5];
  logic [CB-1:0] cnt_q;
  logic [5:0] fp_q;
  logic [6:0] rnd_q;

  logic [5:0] pos;
  logic [63:0] bits;
  logic [31:0] wn, f, k, t;
  logic [7:0] bval;

  // block write position, runs on through the padding
  assign pos = fp_q;
  assign bits = 64'({cnt_q, 3'b000}) & ({64{1'b1}} >> (64 - LengthBits));
  assign status_o.pos = pos;
  assign status_o.last_round = (rnd_q == 7'(sha1_pkg::NumRounds - 1));

  // schedule runs in place on the 16-word window
  always_comb begin
    logic [31:0] x;
    x = w_q[13] ^ w_q[8] ^ w_q[2] ^ w_q[0];
    wn = (rnd_q < 7'd16) ? w_q[0] : {x[30:0], x[31]};
    if (rnd_q < 7'd20) begin
      f = v_q[3] ^ (v_q[1] & (v_q[2] ^ v_q[3]));
      k = sha1_pkg::K0;
    end else if (rnd_q < 7'd40) begin
      f = v_q[1] ^ v_q[2] ^ v_q[3];
      k = sha1_pkg::K1;
    end else if (rnd_q < 7'd60) begin
      f = (v_q[1] & v_q[2]) | (v_q[3] & (v_q[1] | v_q[2]));
      k = sha1_pkg::K2;
    end else begin
      f = v_q[1] ^ v_q[2] ^ v_q[3];
      k = sha1_pkg::K3;
    end
    t = {v_q[0][26:0], v_q[0][31:27]} + f + v_q[4] + k + wn;
  end

  always_comb begin
    bval = data_byte_i;
    if (cmd_i.pad_byte) bval = sha1_pkg::PadByte;
    else if (cmd_i.zero_byte) bval = 8'h00;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_byte || cmd_i.pad_byte || cmd_i.zero_byte) begin
      unique case (pos[1:0])
        2'd0: w_q[pos[5:2]][31:24] <= bval;
        2'd1: w_q[pos[5:2]][23:16] <= bval;
        2'd2: w_q[pos[5:2]][15:8]  <= bval;
        default: w_q[pos[5:2]][7:0] <= bval;
      endcase
    end else if (cmd_i.load_len) begin
      w_q[14] <= bits[63:32];
      w_q[15] <= bits[31:0];
    end else if (cmd_i.round) begin
      for (int i = 0; i < 15; i++) w_q[i] <= w_q[i+1];
      w_q[15] <= wn;
    end
    if (cmd_i.start_comp) begin
      for (int i = 0; i < 5; i++) v_q[i] <= h_q[i];
    end else if (cmd_i.round) begin
      v_q[0] <= t;
      v_q[1] <= v_q[0];
      v_q[2] <= {v_q[1][1:0], v_q[1][31:2]};
      v_q[3] <= v_q[2];
      v_q[4] <= v_q[3];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      h_q[0] <= sha1_pkg::H0Init;
      h_q[1] <= sha1_pkg::H1Init;
      h_q[2] <= sha1_pkg::H2Init;
      h_q[3] <= sha1_pkg::H3Init;
      h_q[4] <= sha1_pkg::H4Init;
      cnt_q <= '0;
      fp_q <= '0;
      rnd_q <= '0;
    end else begin
      if (cmd_i.load_byte) cnt_q <= cnt_q + CB'(1);
      if (cmd_i.load_byte || cmd_i.pad_byte || cmd_i.zero_byte) fp_q <= pos + 6'd1;
      if (cmd_i.round) rnd_q <= status_o.last_round ? 7'd0 : rnd_q + 7'd1;
      if (cmd_i.finish_comp) begin
        for (int i = 0; i < 5; i++) h_q[i] <= h_q[i] + v_q[i];
      end
      if (cmd_i.clear_msg) begin
        h_q[0] <= sha1_pkg::H0Init;
        h_q[1] <= sha1_pkg::H1Init;
        h_q[2] <= sha1_pkg::H2Init;
        h_q[3] <= sha1_pkg::H3Init;
        h_q[4] <= sha1_pkg::H4Init;
        cnt_q <= '0;
        fp_q <= '0;
      end
    end
  end

  always_comb begin
    unique case (out_sel_i)
      3'd0: digest_o = h_q[0];
      3'd1: digest_o = h_q[1];
      3'd2: digest_o = h_q[2];
      3'd3: digest_o = h_q[3];
      default: digest_o = h_q[4];
    endcase
  end

endmodule
`default_nettype wire

// ===== sv/sha1_ctrl.sv =====
`default_nettype none
module sha1_ctrl (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  input  wire logic              byte_present_i,
  input  wire logic              end_of_message_i,
  output logic                   in_ready_o,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output logic [2:0]             out_sel_o,
  output logic                   last_word_o,
  input  wire sha1_pkg::status_t status_i,
  output sha1_pkg::cmd_t         cmd_o
);

  sha1_pkg::state_e state_q, state_d;
  sha1_pkg::state_e ret_q, ret_d;   // where to go once a compression ends
  logic [2:0] sel_q, sel_d;

  assign out_sel_o = sel_q;
  assign last_word_o = (sel_q == 3'd4);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= sha1_pkg::StIdle;
      ret_q <= sha1_pkg::StIdle;
      sel_q <= '0;
    end else begin
      state_q <= state_d;
      ret_q <= ret_d;
      sel_q <= sel_d;
    end
  end

  always_comb begin
    state_d = state_q;
    ret_d = ret_q;
    sel_d = sel_q;
    cmd_o = '0;
    in_ready_o = 1'b0;
    out_valid_o = 1'b0;
    unique case (state_q)
      sha1_pkg::StIdle: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load_byte = byte_present_i;
          if (byte_present_i && status_i.pos == 6'd63) begin
            cmd_o.start_comp = 1'b1;
            state_d = sha1_pkg::StRound;
            ret_d = end_of_message_i ? sha1_pkg::StPadFirst : sha1_pkg::StIdle;
          end else if (end_of_message_i) begin
            state_d = sha1_pkg::StPadFirst;
          end
        end
      end
      sha1_pkg::StPadFirst: begin
        cmd_o.pad_byte = 1'b1;
        if (status_i.pos == 6'd63) begin
          cmd_o.start_comp = 1'b1;
          ret_d = sha1_pkg::StPadFill;
          state_d = sha1_pkg::StRound;
        end else if (status_i.pos == sha1_pkg::LenPos - 6'd1) begin
          state_d = sha1_pkg::StLen;
        end else begin
          state_d = sha1_pkg::StPadFill;
        end
      end
      sha1_pkg::StPadFill: begin
        // zeros up to the length field or to the end of the block
        cmd_o.zero_byte = 1'b1;
        if (status_i.pos == 6'd63) begin
          cmd_o.start_comp = 1'b1;
          ret_d = sha1_pkg::StPadFill;
          state_d = sha1_pkg::StRound;
        end else if (status_i.pos == sha1_pkg::LenPos - 6'd1) begin
          state_d = sha1_pkg::StLen;
        end
      end
      sha1_pkg::StLen: begin
        cmd_o.load_len = 1'b1;
        cmd_o.start_comp = 1'b1;
        ret_d = sha1_pkg::StOut;
        state_d = sha1_pkg::StRound;
      end
      sha1_pkg::StRound: begin
        cmd_o.round = 1'b1;
        if (status_i.last_round) state_d = sha1_pkg::StAfter;
      end
      sha1_pkg::StAfter: begin
        cmd_o.finish_comp = 1'b1;
        sel_d = '0;
        state_d = ret_q;
      end
      sha1_pkg::StOut: begin
        out_valid_o = 1'b1;
        if (out_ready_i) begin
          sel_d = sel_q + 3'd1;
          if (sel_q == 3'd4) begin
            cmd_o.clear_msg = 1'b1;
            ret_d = sha1_pkg::StIdle;
            sel_d = '0;
            state_d = sha1_pkg::StIdle;
          end
        end
      end
      default: state_d = sha1_pkg::StIdle;
    endcase
  end

endmodule
`default_nettype wire

// ===== sv/sha1_byte_stream_hasher.sv =====
// channel | dir | payload
// in      | in  | data_byte, byte_present, end_of_message
// out     | out | digest_word, word_index, last_word
// a byte word is taken whenever the block is idle; each full block then runs its
// rounds on the single round unit, followed by the hash update
// closing a message pads one byte a cycle, between compressions, up to the
// length field and then loads the length, with an extra block when the
// bytes reach past 55; after the last compression come five digest words
// reset restores the initial hash and clears the count at once
// input is held off while padding, compressing or digest words wait on out
`default_nettype none
module sha1_byte_stream_hasher #(
  parameter int unsigned LengthBits = sha1_pkg::LengthBitsDefault
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  sha1_in_if.sink   in_i,
  sha1_out_if.source out_o
);

  sha1_pkg::cmd_t    cmd;
  sha1_pkg::status_t status;
  logic [2:0] sel;

  sha1_ctrl u_ctrl (
    .clk_i,
    .rst_ni,
    .in_valid_i      (in_i.valid),
    .byte_present_i  (in_i.byte_present),
    .end_of_message_i(in_i.end_of_message),
    .in_ready_o      (in_i.ready),
    .out_valid_o     (out_o.valid),
    .out_ready_i     (out_o.ready),
    .out_sel_o       (sel),
    .last_word_o     (out_o.last_word),
    .status_i        (status),
    .cmd_o           (cmd)
  );

  sha1_dp #(.LengthBits(LengthBits)) u_dp (
    .clk_i,
    .rst_ni,
    .data_byte_i(in_i.data_byte),
    .cmd_i      (cmd),
    .out_sel_i  (sel),
    .status_o   (status),
    .digest_o   (out_o.digest_word)
  );

  assign out_o.word_index = sel;

endmodule
`default_nettype wire

// ===== verif/tb_sha1_byte_stream_hasher.sv =====
module tb_sha1_byte_stream_hasher;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;
  } digest_word_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  sha1_in_if  in_ch();
  sha1_out_if out_ch();

  sha1_byte_stream_hasher u_top (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_ch),
    .out_o (out_ch)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // predictor state
  logic [31:0] hash_q [5];
  logic [31:0] blk_q [16];
  logic [60:0] count_q;
  digest_word_t digest_fifo [$];

  int  errors = 0;
  int  idle_cycles = 0;
  bit  hold_sink = 1'b0;
  bit  burst_mode = 1'b1;
  localparam int Watchdog = 20000;

  function automatic logic [31:0] rotl(logic [31:0] x, int n);
    return (x << n) | (x >> (32 - n));
  endfunction

  task automatic hash_init();
    hash_q[0] = sha1_pkg::H0Init; hash_q[1] = sha1_pkg::H1Init;
    hash_q[2] = sha1_pkg::H2Init; hash_q[3] = sha1_pkg::H3Init;
    hash_q[4] = sha1_pkg::H4Init;
    for (int i = 0; i < 16; i++) blk_q[i] = '0;
    count_q = '0;
  endtask

  task automatic put_byte(int pos, logic [7:0] b);
    int w;
    int sh;
    w = pos >> 2;
    sh = (3 - (pos & 3)) * 8;
    blk_q[w] = (blk_q[w] & ~(32'hFF << sh)) | (32'(b) << sh);
  endtask

  task automatic compress_block();
    logic [31:0] a, b, c, d, e, f, k, w, t;
    a = hash_q[0]; b = hash_q[1]; c = hash_q[2]; d = hash_q[3]; e = hash_q[4];
    for (int r = 0; r < 80; r++) begin
      if (r < 16) begin
        w = blk_q[r];
      end else begin
        w = rotl(blk_q[(r - 3) & 15] ^ blk_q[(r - 8) & 15] ^
                 blk_q[(r - 14) & 15] ^ blk_q[r & 15], 1);
        blk_q[r & 15] = w;
      end
      if (r < 20) begin
        f = d ^ (b & (c ^ d)); k = sha1_pkg::K0;
      end else if (r < 40) begin
        f = b ^ c ^ d; k = sha1_pkg::K1;
      end else if (r < 60) begin
        f = (b & c) | (d & (b | c)); k = sha1_pkg::K2;
      end else begin
        f = b ^ c ^ d; k = sha1_pkg::K3;
      end
      t = rotl(a, 5) + f + e + k + w;
      e = d; d = c; c = rotl(b, 30); b = a; a = t;
    end
    hash_q[0] += a; hash_q[1] += b; hash_q[2] += c; hash_q[3] += d; hash_q[4] += e;
  endtask

  task automatic predict_digest(logic [7:0] data, logic present, logic eom);
    logic [63:0] bits;
    int pos;
    digest_word_t dw;
    if (present) begin
      put_byte(int'(count_q[5:0]), data);
      count_q = count_q + 61'd1;
      if (count_q[5:0] == 6'd0) compress_block();
    end
    if (eom) begin
      bits = {count_q, 3'b000};
      pos = int'(count_q[5:0]);
      put_byte(pos, sha1_pkg::PadByte);
      for (int i = pos + 1; i < 64; i++) put_byte(i, 8'h00);
      if (pos >= 56) begin
        compress_block();
        for (int i = 0; i < 16; i++) blk_q[i] = '0;
      end
      blk_q[14] = bits[63:32];
      blk_q[15] = bits[31:0];
      compress_block();
      for (int i = 0; i < 5; i++) begin
        dw.digest_word = hash_q[i];
        dw.word_index = 3'(i);
        dw.last_word = (i == 4);
        digest_fifo.push_back(dw);
      end
      hash_init();
    end
  endtask

  // sender with bursts and gaps
  int burst_left = 0;

  task automatic send_byte_item(logic [7:0] data, logic present, logic eom);
    int gap;
    gap = 0;
    if (burst_mode) begin
      if (burst_left == 0) begin
        gap = $urandom_range(0, 6);
        burst_left = $urandom_range(1, 20);
      end
      burst_left--;
    end
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_ch.valid <= 1'b1;
    in_ch.data_byte <= data;
    in_ch.byte_present <= present;
    in_ch.end_of_message <= eom;
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
    predict_digest(data, present, eom);
  endtask

  task automatic send_message(int len);
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(0, 9) == 0) send_byte_item(8'($urandom), 1'b0, 1'b0);
      send_byte_item(8'($urandom), 1'b1, 1'b0);
    end
    if ($urandom_range(0, 1) != 0) send_byte_item(8'($urandom), 1'b0, 1'b1);
    else send_byte_item(8'($urandom), 1'b1, 1'b1);
  endtask

  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    @(posedge clk_i);
    while (digest_fifo.size() != 0) @(posedge clk_i);
  endtask

  // receiver stall pattern and checker
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= !hold_sink && ($urandom_range(0, 3) != 0);
      if (out_ch.valid && out_ch.ready) begin
        if (digest_fifo.size() == 0) begin
          $error("unexpected digest word %h", out_ch.digest_word);
          errors++;
        end else begin
          digest_word_t exp_w;
          exp_w = digest_fifo.pop_front();
          if (out_ch.digest_word !== exp_w.digest_word) begin
            $error("digest_word exp %h got %h", exp_w.digest_word, out_ch.digest_word);
            errors++;
          end
          if (out_ch.word_index !== exp_w.word_index) begin
            $error("word_index exp %0d got %0d", exp_w.word_index, out_ch.word_index);
            errors++;
          end
          if (out_ch.last_word !== exp_w.last_word) begin
            $error("last_word exp %0d got %0d", exp_w.last_word, out_ch.last_word);
            errors++;
          end
        end
      end
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || hold_sink)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= Watchdog) begin
      $display("Some tests failed");
      $finish;
    end
  end

  task automatic test_directed();
    send_byte_item(8'h00, 1'b0, 1'b0);
    send_byte_item(8'hFF, 1'b0, 1'b1);   // empty message
    send_byte_item("a", 1'b1, 1'b0);
    send_byte_item("b", 1'b1, 1'b0);
    send_byte_item("c", 1'b1, 1'b1);     // byte and end together
    send_byte_item(8'hFF, 1'b1, 1'b1);
    send_byte_item(8'h00, 1'b1, 1'b1);
    wait_drained();
  endtask

  task automatic test_padding_edges();
    int lens [4] = '{55, 56, 63, 64};
    foreach (lens[i]) send_message(lens[i]);
    wait_drained();
  endtask

  task automatic test_backpressure();
    fork
      begin
        hold_sink = 1'b1;
        repeat (600) @(posedge clk_i);
        hold_sink = 1'b0;
      end
      begin
        burst_mode = 1'b0;
        send_message(3);
        send_message(0);
        send_message(10);
        burst_mode = 1'b1;
      end
    join
    wait_drained();
  endtask

  task automatic test_random_messages();
    int sent;
    sent = 0;
    while (sent < 80) begin
      int len;
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(56, 72) : $urandom_range(0, 20);
      send_message(len);
      sent += len + 1;
      if ($urandom_range(0, 7) == 0) wait_drained();
    end
    wait_drained();
  endtask

  initial begin
    in_ch.valid = 1'b0;
    in_ch.data_byte = '0;
    in_ch.byte_present = 1'b0;
    in_ch.end_of_message = 1'b0;
    out_ch.ready = 1'b0;
    hash_init();
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_padding_edges();
    test_backpressure();
    test_random_messages();
    repeat (200) @(posedge clk_i);
    if (errors == 0 && digest_fifo.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// ===== sha1_byte_stream_hasher.f =====
sv/sha1_pkg.sv
sv/sha1_if.sv
sv/sha1_dp.sv
sv/sha1_ctrl.sv
sv/sha1_byte_stream_hasher.sv
verif/tb_sha1_byte_stream_hasher.sv
